// File: hw/rtl/fbpa_pkg.sv
// shared types, codes and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int DEF_MAX_BLOCKS       = 256;
    localparam int DEF_QUARANTINE_DEPTH = 16;
    localparam int DEF_LINE_BYTES       = 32;

    // serial divider operand widths
    localparam int DIV_DVD_W = 33;
    localparam int DIV_DSR_W = 17;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BASE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_SIZE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_SIZE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUAR_CAP     = 3'd4;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_INIT  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_TAKEN   = 3'd2;
    localparam logic [2:0] ST_BADADDR = 3'd3;
    localparam logic [2:0] ST_DOUBLE  = 3'd4;
    localparam logic [2:0] ST_NOMEM   = 3'd5;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DIV_CAP,
        OP_FAIL_NOMEM,
        OP_COMMIT,
        OP_END,
        OP_FILL,
        OP_RING_RD,
        OP_Q_TO_STACK,
        OP_POP,
        OP_EMPTY,
        OP_GOT_ID,
        OP_TAKEN,
        OP_ALLOC,
        OP_ADDR,
        OP_BAD,
        OP_DIV_ID,
        OP_ID,
        OP_DOUBLE,
        OP_FREE,
        OP_Q_WR
    } op_t;

    typedef struct packed {
        logic       div_done;
        logic       init_bad;
        logic       cap_short;
        logic       q_move;
        logic       q_full;
        logic       q_off;
        logic       stack_empty;
        logic       fill_last;
        logic       range_bad;
        logic       rem_nz;
        logic       map_set;
        logic [1:0] mode;
    } dp_stat_t;

endpackage

// File: hw/rtl/fbpa_div.sv
// restoring divider, one quotient bit per cycle
module fbpa_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fbpa_pkg::DIV_DVD_W-1:0] dividend,
    input  logic [fbpa_pkg::DIV_DSR_W-1:0] divisor,
    output logic                           done,
    output logic [fbpa_pkg::DIV_DVD_W-1:0] quotient,
    output logic [fbpa_pkg::DIV_DSR_W-1:0] remainder
);

    localparam int QW = fbpa_pkg::DIV_DVD_W;
    localparam int RW = fbpa_pkg::DIV_DSR_W;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] q_reg;
    logic [RW:0]   r_reg;
    logic [RW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [RW:0]   shifted;
    logic          ge;
    logic [RW:0]   r_next;

    assign shifted = {r_reg[RW-1:0], q_reg[QW-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign r_next  = ge ? (shifted - {1'b0, d_reg}) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(QW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            q_reg <= {q_reg[QW-2:0], ge};
            r_reg <= r_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[RW-1:0];

endmodule

// File: hw/rtl/fbpa_datapath.sv
// allocator datapath: configuration, stores, counters and the divider
module fbpa_datapath #(
    parameter int MAX_BLOCKS       = fbpa_pkg::DEF_MAX_BLOCKS,
    parameter int QUARANTINE_DEPTH = fbpa_pkg::DEF_QUARANTINE_DEPTH,
    parameter int LINE_BYTES       = fbpa_pkg::DEF_LINE_BYTES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]                       mode,
    input  logic [31:0]                      free_address,
    input  fbpa_pkg::op_t                    op,
    output fbpa_pkg::dp_stat_t               stat,
    output logic [2:0]                       status,
    output logic [7:0]                       block_id,
    output logic [31:0]                      block_address,
    output logic [8:0]                       in_use,
    output logic [8:0]                       peak_in_use,
    output logic [31:0]                      alloc_ok_count,
    output logic [31:0]                      alloc_fail_count,
    output logic [31:0]                      free_ok_count,
    output logic [31:0]                      free_fail_count,
    output logic [31:0]                      double_free_count
);

    localparam int IDW = $clog2(MAX_BLOCKS);
    localparam int DW  = $clog2(MAX_BLOCKS + 1);
    localparam int QIW = (QUARANTINE_DEPTH > 1) ? $clog2(QUARANTINE_DEPTH) : 1;
    localparam int QFW = $clog2(QUARANTINE_DEPTH + 1);
    localparam int PW  = 16 + DW;
    localparam int DVW = fbpa_pkg::DIV_DVD_W;
    localparam int DSW = fbpa_pkg::DIV_DSR_W;

    logic [31:0] pool_base_reg;
    logic [31:0] pool_size_reg;
    logic [15:0] payload_size_reg;
    logic [8:0]  block_count_reg;
    logic [4:0]  quar_cap_reg;

    logic [1:0]     mode_reg;
    logic [31:0]    addr_reg;
    logic [31:0]    aligned_start_reg;
    logic [15:0]    stride_reg;
    logic [DW-1:0]  active_reg;
    logic [DVW-1:0] pool_end_reg;
    logic [PW-1:0]  prod_reg;
    logic [QFW-1:0] q_limit_reg;
    logic [QIW-1:0] q_rd_reg;
    logic [QIW-1:0] q_wr_reg;
    logic [QFW-1:0] q_fill_reg;
    logic [DW-1:0]  depth_reg;
    logic [DW-1:0]  fill_idx_reg;
    logic [DW-1:0]  in_use_reg;
    logic [DW-1:0]  peak_reg;
    logic [31:0]    alloc_ok_reg;
    logic [31:0]    alloc_fail_reg;
    logic [31:0]    free_ok_reg;
    logic [31:0]    free_fail_reg;
    logic [31:0]    double_reg;
    logic [IDW-1:0] id_reg;
    logic [2:0]     status_reg;
    logic [7:0]     id_out_reg;
    logic [31:0]    addr_out_reg;

    logic [IDW-1:0] stack_mem [MAX_BLOCKS];
    logic           map_mem   [MAX_BLOCKS];
    logic [IDW-1:0] ring_mem  [QUARANTINE_DEPTH];
    logic [IDW-1:0] stack_rdata_reg;
    logic           map_rdata_reg;
    logic [IDW-1:0] ring_rdata_reg;

    logic [DVW-1:0] align_dvd;
    logic [DVW-1:0] stride_dvd;
    logic [DVW-1:0] aligned_tmp;
    logic [DSW-1:0] stride_tmp;
    logic [DVW-1:0] lost;
    logic [DVW-1:0] cap_dvd;
    logic [31:0]    offset;
    logic           div_start;
    logic [DVW-1:0] div_dvd;
    logic [DSW-1:0] div_dsr;
    logic           div_done;
    logic [DVW-1:0] div_quot;
    logic [DSW-1:0] div_rem;
    logic           push_ok;
    logic [DW-1:0]  pop_idx;
    logic [QIW-1:0] q_rd_next;
    logic [QIW-1:0] q_wr_next;
    logic [DW-1:0]  in_use_inc;

    // round up to a whole line with a mask, the line size being a power of two
    assign align_dvd   = {1'b0, pool_base_reg} + DVW'(LINE_BYTES - 1);
    assign stride_dvd  = DVW'(payload_size_reg) + DVW'(LINE_BYTES - 1);
    assign aligned_tmp = align_dvd & ~DVW'(LINE_BYTES - 1);
    assign stride_tmp  = DSW'(stride_dvd & ~DVW'(LINE_BYTES - 1));
    assign lost        = aligned_tmp - {1'b0, pool_base_reg};
    assign cap_dvd     = {1'b0, pool_size_reg} - lost;
    assign offset      = addr_reg - aligned_start_reg;

    always_comb
    begin
        div_start = 1'b0;
        unique case (op)
            fbpa_pkg::OP_DIV_CAP:
            begin
                div_start = 1'b1;
                div_dvd   = cap_dvd;
                div_dsr   = stride_tmp;
            end
            default:
            begin
                div_start = (op == fbpa_pkg::OP_DIV_ID);
                div_dvd   = {1'b0, offset};
                div_dsr   = {1'b0, stride_reg};
            end
        endcase
    end

    fbpa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign push_ok    = depth_reg < DW'(MAX_BLOCKS);
    assign pop_idx    = depth_reg - DW'(1);
    assign in_use_inc = in_use_reg + DW'(1);
    // ring pointers wrap at the configured limit, not the store depth
    assign q_rd_next  = (QFW'(q_rd_reg) + QFW'(1) == q_limit_reg) ? '0 : q_rd_reg + QIW'(1);
    assign q_wr_next  = (QFW'(q_wr_reg) + QFW'(1) == q_limit_reg) ? '0 : q_wr_reg + QIW'(1);

    always_comb
    begin
        stat.div_done    = div_done;
        stat.init_bad    = (block_count_reg == '0) || (payload_size_reg == '0)
                           || (pool_size_reg == '0) || (lost >= {1'b0, pool_size_reg})
                           || (stride_tmp > DSW'(65535))
                           || ({23'b0, block_count_reg} > 32'(MAX_BLOCKS));
        stat.cap_short   = div_quot < DVW'(block_count_reg);
        stat.q_move      = (q_fill_reg != '0) && (q_limit_reg != '0);
        stat.q_full      = q_fill_reg >= q_limit_reg;
        stat.q_off       = q_limit_reg == '0;
        stat.stack_empty = depth_reg == '0;
        stat.fill_last   = (fill_idx_reg + DW'(1)) == active_reg;
        stat.range_bad   = ({1'b0, addr_reg} < {1'b0, aligned_start_reg})
                           || ({1'b0, addr_reg} >= pool_end_reg);
        stat.rem_nz      = div_rem != '0;
        stat.map_set     = map_rdata_reg;
        stat.mode        = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg    <= '0;
            pool_size_reg    <= 32'd8192;
            payload_size_reg <= 16'd32;
            block_count_reg  <= 9'd256;
            quar_cap_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_POOL_BASE:    pool_base_reg    <= cfg_data;
                fbpa_pkg::CFG_POOL_SIZE:    pool_size_reg    <= cfg_data;
                fbpa_pkg::CFG_PAYLOAD_SIZE: payload_size_reg <= cfg_data[15:0];
                fbpa_pkg::CFG_BLOCK_COUNT:  block_count_reg  <= cfg_data[8:0];
                fbpa_pkg::CFG_QUAR_CAP:     quar_cap_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // stores: no reset, entries are written before they are read
    always_ff @(posedge clk)
    begin
        unique case (op)
            fbpa_pkg::OP_FILL:
            begin
                stack_mem[fill_idx_reg[IDW-1:0]] <= fill_idx_reg[IDW-1:0];
                map_mem[fill_idx_reg[IDW-1:0]]   <= 1'b0;
            end
            fbpa_pkg::OP_RING_RD:    ring_rdata_reg <= ring_mem[q_rd_reg];
            fbpa_pkg::OP_Q_TO_STACK:
            begin
                if (push_ok)
                begin
                    stack_mem[depth_reg[IDW-1:0]] <= ring_rdata_reg;
                end
            end
            fbpa_pkg::OP_POP:        stack_rdata_reg <= stack_mem[pop_idx[IDW-1:0]];
            fbpa_pkg::OP_GOT_ID:     map_rdata_reg   <= map_mem[stack_rdata_reg];
            fbpa_pkg::OP_ID:         map_rdata_reg   <= map_mem[div_quot[IDW-1:0]];
            fbpa_pkg::OP_ALLOC:      map_mem[id_reg] <= 1'b1;
            fbpa_pkg::OP_FREE:
            begin
                map_mem[id_reg] <= 1'b0;
                if (stat.q_off && push_ok)
                begin
                    stack_mem[depth_reg[IDW-1:0]] <= id_reg;
                end
            end
            fbpa_pkg::OP_Q_WR:       ring_mem[q_wr_reg] <= id_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aligned_start_reg <= '0;
            stride_reg        <= 16'(LINE_BYTES);
            active_reg        <= '0;
            pool_end_reg      <= '0;
            q_limit_reg       <= '0;
            q_rd_reg          <= '0;
            q_wr_reg          <= '0;
            q_fill_reg        <= '0;
            depth_reg         <= '0;
            fill_idx_reg      <= '0;
            in_use_reg        <= '0;
            peak_reg          <= '0;
            alloc_ok_reg      <= '0;
            alloc_fail_reg    <= '0;
            free_ok_reg       <= '0;
            free_fail_reg     <= '0;
            double_reg        <= '0;
            mode_reg          <= '0;
            status_reg        <= fbpa_pkg::ST_OK;
            id_out_reg        <= '0;
            addr_out_reg      <= '0;
        end
        else
        begin
            unique case (op)
                fbpa_pkg::OP_ACCEPT:
                begin
                    mode_reg     <= mode;
                    status_reg   <= fbpa_pkg::ST_OK;
                    id_out_reg   <= '0;
                    addr_out_reg <= '0;
                end
                fbpa_pkg::OP_FAIL_NOMEM: status_reg <= fbpa_pkg::ST_NOMEM;
                fbpa_pkg::OP_COMMIT:
                begin
                    aligned_start_reg <= aligned_tmp[31:0];
                    stride_reg        <= stride_tmp[15:0];
                    active_reg        <= DW'(block_count_reg);
                    q_limit_reg       <= ({27'b0, quar_cap_reg} > 32'(QUARANTINE_DEPTH))
                                         ? QFW'(QUARANTINE_DEPTH) : QFW'(quar_cap_reg);
                    q_rd_reg          <= '0;
                    q_wr_reg          <= '0;
                    q_fill_reg        <= '0;
                    depth_reg         <= '0;
                    fill_idx_reg      <= '0;
                    in_use_reg        <= '0;
                    peak_reg          <= '0;
                    alloc_ok_reg      <= '0;
                    alloc_fail_reg    <= '0;
                    free_ok_reg       <= '0;
                    free_fail_reg     <= '0;
                    double_reg        <= '0;
                end
                fbpa_pkg::OP_END:
                begin
                    pool_end_reg <= {1'b0, aligned_start_reg} + DVW'(prod_reg);
                end
                fbpa_pkg::OP_FILL:
                begin
                    fill_idx_reg <= fill_idx_reg + DW'(1);
                    depth_reg    <= fill_idx_reg + DW'(1);
                end
                fbpa_pkg::OP_Q_TO_STACK:
                begin
                    q_rd_reg   <= q_rd_next;
                    q_fill_reg <= q_fill_reg - QFW'(1);
                    if (push_ok)
                    begin
                        depth_reg <= depth_reg + DW'(1);
                    end
                end
                fbpa_pkg::OP_POP:        depth_reg <= pop_idx;
                fbpa_pkg::OP_EMPTY:
                begin
                    status_reg     <= fbpa_pkg::ST_EMPTY;
                    alloc_fail_reg <= alloc_fail_reg + 32'd1;
                end
                fbpa_pkg::OP_TAKEN:
                begin
                    status_reg     <= fbpa_pkg::ST_TAKEN;
                    alloc_fail_reg <= alloc_fail_reg + 32'd1;
                end
                fbpa_pkg::OP_ALLOC:
                begin
                    in_use_reg   <= in_use_inc;
                    peak_reg     <= (in_use_inc > peak_reg) ? in_use_inc : peak_reg;
                    alloc_ok_reg <= alloc_ok_reg + 32'd1;
                    id_out_reg   <= 8'(id_reg);
                end
                fbpa_pkg::OP_ADDR:
                begin
                    addr_out_reg <= aligned_start_reg + 32'(prod_reg);
                end
                fbpa_pkg::OP_BAD:
                begin
                    status_reg    <= fbpa_pkg::ST_BADADDR;
                    free_fail_reg <= free_fail_reg + 32'd1;
                end
                fbpa_pkg::OP_DOUBLE:
                begin
                    status_reg <= fbpa_pkg::ST_DOUBLE;
                    double_reg <= double_reg + 32'd1;
                end
                fbpa_pkg::OP_FREE:
                begin
                    if (in_use_reg != '0)
                    begin
                        in_use_reg <= in_use_reg - DW'(1);
                    end
                    free_ok_reg <= free_ok_reg + 32'd1;
                    id_out_reg  <= 8'(id_reg);
                    if (stat.q_off && push_ok)
                    begin
                        depth_reg <= depth_reg + DW'(1);
                    end
                end
                fbpa_pkg::OP_Q_WR:
                begin
                    q_wr_reg   <= q_wr_next;
                    q_fill_reg <= q_fill_reg + QFW'(1);
                end
                default: ;
            endcase
        end
    end

    // payload-only registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            fbpa_pkg::OP_ACCEPT:     addr_reg <= free_address;
            fbpa_pkg::OP_COMMIT:
            begin
                prod_reg <= PW'(PW'(stride_tmp[15:0]) * PW'(DW'(block_count_reg)));
            end
            fbpa_pkg::OP_GOT_ID:     id_reg <= stack_rdata_reg;
            fbpa_pkg::OP_ALLOC:      prod_reg <= PW'(PW'(id_reg) * PW'(stride_reg));
            fbpa_pkg::OP_ID:         id_reg <= div_quot[IDW-1:0];
            default: ;
        endcase
    end

    assign status            = status_reg;
    assign block_id          = id_out_reg;
    assign block_address     = addr_out_reg;
    assign in_use            = 9'(in_use_reg);
    assign peak_in_use       = 9'(peak_reg);
    assign alloc_ok_count    = alloc_ok_reg;
    assign alloc_fail_count  = alloc_fail_reg;
    assign free_ok_count     = free_ok_reg;
    assign free_fail_count   = free_fail_reg;
    assign double_free_count = double_reg;

endmodule

// File: hw/rtl/fbpa_ctrl.sv
// allocator sequencer: steps the datapath through init, alloc and free
module fbpa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  fbpa_pkg::dp_stat_t stat,
    output fbpa_pkg::op_t      op
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_I_CHK,
        S_I_WC,
        S_I_END,
        S_I_FILL,
        S_A_Q,
        S_A_QPUSH,
        S_A_POP,
        S_A_MAP,
        S_A_CHK,
        S_A_ADDR,
        S_F_CHK,
        S_F_WAIT,
        S_F_MAP,
        S_F_QRD,
        S_F_QMOVE,
        S_F_QWR,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        op         = fbpa_pkg::OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = fbpa_pkg::OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.mode)
                    fbpa_pkg::MODE_INIT:  state_next = S_I_CHK;
                    fbpa_pkg::MODE_ALLOC: state_next = S_A_Q;
                    fbpa_pkg::MODE_FREE:  state_next = S_F_CHK;
                    default:              state_next = S_OUT;
                endcase
            end
            S_I_CHK:
            begin
                if (stat.init_bad)
                begin
                    op         = fbpa_pkg::OP_FAIL_NOMEM;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = fbpa_pkg::OP_DIV_CAP;
                    state_next = S_I_WC;
                end
            end
            S_I_WC:
            begin
                if (stat.div_done)
                begin
                    if (stat.cap_short)
                    begin
                        op         = fbpa_pkg::OP_FAIL_NOMEM;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        op         = fbpa_pkg::OP_COMMIT;
                        state_next = S_I_END;
                    end
                end
            end
            S_I_END:
            begin
                op         = fbpa_pkg::OP_END;
                state_next = S_I_FILL;
            end
            S_I_FILL:
            begin
                op = fbpa_pkg::OP_FILL;
                if (stat.fill_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_A_Q:
            begin
                if (stat.q_move)
                begin
                    op         = fbpa_pkg::OP_RING_RD;
                    state_next = S_A_QPUSH;
                end
                else
                begin
                    state_next = S_A_POP;
                end
            end
            S_A_QPUSH:
            begin
                op         = fbpa_pkg::OP_Q_TO_STACK;
                state_next = S_A_POP;
            end
            S_A_POP:
            begin
                if (stat.stack_empty)
                begin
                    op         = fbpa_pkg::OP_EMPTY;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = fbpa_pkg::OP_POP;
                    state_next = S_A_MAP;
                end
            end
            S_A_MAP:
            begin
                op         = fbpa_pkg::OP_GOT_ID;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (stat.map_set)
                begin
                    op         = fbpa_pkg::OP_TAKEN;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = fbpa_pkg::OP_ALLOC;
                    state_next = S_A_ADDR;
                end
            end
            S_A_ADDR:
            begin
                op         = fbpa_pkg::OP_ADDR;
                state_next = S_OUT;
            end
            S_F_CHK:
            begin
                if (stat.range_bad)
                begin
                    op         = fbpa_pkg::OP_BAD;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = fbpa_pkg::OP_DIV_ID;
                    state_next = S_F_WAIT;
                end
            end
            S_F_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_nz)
                    begin
                        op         = fbpa_pkg::OP_BAD;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        op         = fbpa_pkg::OP_ID;
                        state_next = S_F_MAP;
                    end
                end
            end
            S_F_MAP:
            begin
                if (!stat.map_set)
                begin
                    op         = fbpa_pkg::OP_DOUBLE;
                    state_next = S_OUT;
                end
                else
                begin
                    op = fbpa_pkg::OP_FREE;
                    priority if (stat.q_off)
                    begin
                        state_next = S_OUT;
                    end
                    else if (stat.q_full)
                    begin
                        state_next = S_F_QRD;
                    end
                    else
                    begin
                        state_next = S_F_QWR;
                    end
                end
            end
            S_F_QRD:
            begin
                op         = fbpa_pkg::OP_RING_RD;
                state_next = S_F_QMOVE;
            end
            S_F_QMOVE:
            begin
                op         = fbpa_pkg::OP_Q_TO_STACK;
                state_next = S_F_QWR;
            end
            S_F_QWR:
            begin
                op         = fbpa_pkg::OP_Q_WR;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;

endmodule

// File: hw/rtl/fixed_block_pool_allocator_top.sv
// top level of the fixed block pool allocator
//
// Handles one request at a time and holds its result on the output until it
// is taken. An allocate does registered reads of the quarantine ring, when a
// quarantined block is moved back first, then of the free stack and the
// allocation map in turn, and stops before the stack read when the stack is
// empty. A free needs no division when the address lies outside the pool;
// otherwise the one-bit-per-cycle divider turns the pool offset into a block
// id, and quarantine work may follow. An initialize needs no division when
// the configuration is rejected outright; otherwise one division gives the
// capacity, the request ends there when too few blocks fit, and else the
// free stack is filled and the allocation map cleared, one block at a time.
// Line rounding is done with a mask, so LINE_BYTES must be a power of two.
// The stores need no clearing pass after reset. Configuration is latched
// only by an initialize request.
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS       = fbpa_pkg::DEF_MAX_BLOCKS,
    parameter int QUARANTINE_DEPTH = fbpa_pkg::DEF_QUARANTINE_DEPTH,
    parameter int LINE_BYTES       = fbpa_pkg::DEF_LINE_BYTES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       mode,
    input  logic [31:0]                      free_address,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       status,
    output logic [7:0]                       block_id,
    output logic [31:0]                      block_address,
    output logic [8:0]                       in_use,
    output logic [8:0]                       peak_in_use,
    output logic [31:0]                      alloc_ok_count,
    output logic [31:0]                      alloc_fail_count,
    output logic [31:0]                      free_ok_count,
    output logic [31:0]                      free_fail_count,
    output logic [31:0]                      double_free_count
);

    fbpa_pkg::op_t      op;
    fbpa_pkg::dp_stat_t stat;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .op        (op)
    );

    fbpa_datapath #(
        .MAX_BLOCKS       (MAX_BLOCKS),
        .QUARANTINE_DEPTH (QUARANTINE_DEPTH),
        .LINE_BYTES       (LINE_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mode              (mode),
        .free_address      (free_address),
        .op                (op),
        .stat              (stat),
        .status            (status),
        .block_id          (block_id),
        .block_address     (block_address),
        .in_use            (in_use),
        .peak_in_use       (peak_in_use),
        .alloc_ok_count    (alloc_ok_count),
        .alloc_fail_count  (alloc_fail_count),
        .free_ok_count     (free_ok_count),
        .free_fail_count   (free_fail_count),
        .double_free_count (double_free_count)
    );

    // no request is taken while a result is pending
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while a result is pending");

    // a result never appears in the cycle right after a request is taken
    a_result_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result shown before the request was processed");

    // the peak level never falls below the current level
    a_peak_covers_use: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_use <= peak_in_use))
        else $error("in_use above peak_in_use");

endmodule
